### rtl/tst_pkg.sv
// Shared types, codes and constants of the timer slot table.
package tst_pkg;

    localparam int SlotsDefault = 16;
    localparam int MaxFire = 16;
    localparam int FireCntW = $clog2(MaxFire + 1);

    localparam logic [2:0] KindStartShort = 3'd0;
    localparam logic [2:0] KindStartLong = 3'd1;
    localparam logic [2:0] KindCancel = 3'd2;
    localparam logic [2:0] KindQuery = 3'd3;
    localparam logic [2:0] KindProcess = 3'd4;

    localparam logic [1:0] StatusOk = 2'd0;
    localparam logic [1:0] StatusNoSlot = 2'd1;
    localparam logic [1:0] StatusZeroOwner = 2'd2;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  owner_id;
        logic [15:0] data_tag;
        logic [15:0] count;
        logic        tick_event;
        logic        second_event;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  status;
        logic        running;
        logic        fired;
        logic [7:0]  fired_owner;
        logic [15:0] fired_tag;
        logic        last;
    } t_out_beat;

    typedef struct packed {
        logic [7:0]  owner;
        logic [15:0] tag;
        logic [15:0] ticks;
        logic [15:0] seconds;
    } t_slot;

endpackage

### rtl/tst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/timer_slot_table.sv
// Top level of the timer slot table: command sequencer, slot scan and result register.
//
// Commands enter on the input channel (i_in_valid, o_in_stall, i_in_beat) and
// results leave on the output channel (o_out_valid, i_out_stall, o_out_beat).
// A start, cancel or query gives one result beat; a process step gives one beat
// per expired slot, up to MaxFire, or a single beat with fired low when none
// expired. The final beat of every command carries last.
// Each start, cancel or query with a nonzero owner, and every process step, walks the
// slot table one entry per cycle through the table RAM, unless a process step
// pauses for a stalled receiver; a command rejected for a zero owner, or of unknown
// kind, skips the walk. The walk is bounded by the single RAM read port.
// The input channel is stalled while a command is in progress. The result
// register lets the next command be accepted while the last beat still waits.
// When the receiver stalls, a process step pauses its walk on the next expired
// slot until the result register can take the pending beat.
// Reset frees every slot at once through the armed flags; the RAM contents
// need no clearing.
module timer_slot_table import tst_pkg::*; #(
    parameter int SLOTS = SlotsDefault
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_beat
);

    localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);

    localparam logic [1:0] StIdle = 2'd0;
    localparam logic [1:0] StScan = 2'd1;
    localparam logic [1:0] StFin = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [IdxW-1:0]     r_idx, n_idx;
    t_in_beat            r_cmd, n_cmd;
    logic [SLOTS-1:0]    r_armed, n_armed;
    logic                r_hit, n_hit;
    logic [FireCntW-1:0] r_nfire, n_nfire;
    logic                r_pend_valid, n_pend_valid;
    logic [7:0]          r_pend_owner, n_pend_owner;
    logic [15:0]         r_pend_tag, n_pend_tag;
    logic                r_out_valid, n_out_valid;
    t_out_beat           r_out, n_out;

    logic            ram_we;
    logic            ram_re;
    logic [IdxW-1:0] ram_raddr;
    t_slot           ram_wdata;
    t_slot           rd_slot;
    logic            can_push;
    logic            push;
    t_out_beat       push_beat;
    logic            accept;
    logic            slot_armed;
    logic            owner_eq;
    logic            tag_eq;
    logic [15:0]     dec_ticks;
    logic [15:0]     dec_seconds;
    logic            fire;

    tst_ram #(
        .WIDTH($bits(t_slot)),
        .DEPTH(SLOTS)
    ) u_table (
        .i_clk(i_clk),
        .i_we(ram_we),
        .i_waddr(r_idx),
        .i_wdata(ram_wdata),
        .i_re(ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(rd_slot)
    );

    assign can_push = !r_out_valid || !i_out_stall;
    assign accept = i_in_valid && (r_state == StIdle);

    assign slot_armed = r_armed[r_idx];
    assign owner_eq = rd_slot.owner == r_cmd.owner_id;
    assign tag_eq = rd_slot.tag == r_cmd.data_tag;
    assign dec_ticks = (r_cmd.tick_event && rd_slot.ticks != 16'd0) ?
                       rd_slot.ticks - 16'd1 : rd_slot.ticks;
    assign dec_seconds = (r_cmd.second_event && rd_slot.seconds != 16'd0) ?
                         rd_slot.seconds - 16'd1 : rd_slot.seconds;
    assign fire = slot_armed && dec_ticks == 16'd0 && dec_seconds == 16'd0 &&
                  r_nfire < FireCntW'(MaxFire);

    always_comb begin
        n_state = r_state;
        n_idx = r_idx;
        n_cmd = r_cmd;
        n_armed = r_armed;
        n_hit = r_hit;
        n_nfire = r_nfire;
        n_pend_valid = r_pend_valid;
        n_pend_owner = r_pend_owner;
        n_pend_tag = r_pend_tag;
        ram_we = 1'b0;
        ram_re = 1'b0;
        ram_raddr = r_idx + IdxW'(1);
        ram_wdata = rd_slot;
        push = 1'b0;
        push_beat = '0;

        unique case (r_state)
            StIdle: begin
                if (accept) begin
                    n_cmd = i_in_beat;
                    n_idx = '0;
                    n_hit = 1'b0;
                    n_nfire = '0;
                    n_pend_valid = 1'b0;
                    if (i_in_beat.kind == KindProcess ||
                        ((i_in_beat.kind inside {KindStartShort, KindStartLong,
                                                 KindCancel, KindQuery}) &&
                         i_in_beat.owner_id != 8'd0)) begin
                        ram_re = 1'b1;
                        ram_raddr = '0;
                        n_state = StScan;
                    end else begin
                        n_state = StFin;
                    end
                end
            end
            StScan: begin
                if (!(r_cmd.kind == KindProcess && fire && r_pend_valid && !can_push)) begin
                    case (r_cmd.kind) inside
                        KindStartShort, KindStartLong: begin
                            if (!r_hit && (!slot_armed || (owner_eq && tag_eq))) begin
                                ram_we = 1'b1;
                                ram_wdata.owner = r_cmd.owner_id;
                                ram_wdata.tag = r_cmd.data_tag;
                                ram_wdata.ticks = (r_cmd.kind == KindStartShort) ?
                                                  r_cmd.count : 16'd0;
                                ram_wdata.seconds = (r_cmd.kind == KindStartLong) ?
                                                    r_cmd.count : 16'd0;
                                n_armed[r_idx] = 1'b1;
                                n_hit = 1'b1;
                            end
                        end
                        KindCancel: begin
                            if (!r_hit && slot_armed && owner_eq &&
                                (r_cmd.data_tag == 16'd0 || tag_eq)) begin
                                n_armed[r_idx] = 1'b0;
                                n_hit = r_cmd.data_tag != 16'd0;
                            end
                        end
                        KindQuery: begin
                            if (slot_armed && owner_eq &&
                                (r_cmd.data_tag == 16'd0 || tag_eq)) begin
                                n_hit = 1'b1;
                            end
                        end
                        KindProcess: begin
                            ram_we = 1'b1;
                            ram_wdata.ticks = dec_ticks;
                            ram_wdata.seconds = dec_seconds;
                            if (fire) begin
                                n_armed[r_idx] = 1'b0;
                                n_nfire = r_nfire + FireCntW'(1);
                                n_pend_valid = 1'b1;
                                n_pend_owner = rd_slot.owner;
                                n_pend_tag = rd_slot.tag;
                                if (r_pend_valid) begin
                                    push = 1'b1;
                                    push_beat.fired = 1'b1;
                                    push_beat.fired_owner = r_pend_owner;
                                    push_beat.fired_tag = r_pend_tag;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (r_idx == LastIdx) begin
                        n_state = StFin;
                    end else begin
                        ram_re = 1'b1;
                        n_idx = r_idx + IdxW'(1);
                    end
                end
            end
            StFin: begin
                if (can_push) begin
                    push = 1'b1;
                    push_beat.last = 1'b1;
                    case (r_cmd.kind) inside
                        KindProcess: begin
                            if (r_pend_valid) begin
                                push_beat.fired = 1'b1;
                                push_beat.fired_owner = r_pend_owner;
                                push_beat.fired_tag = r_pend_tag;
                            end
                        end
                        KindStartShort, KindStartLong, KindCancel, KindQuery: begin
                            if (r_cmd.owner_id == 8'd0) begin
                                push_beat.status = StatusZeroOwner;
                            end else if (r_cmd.kind == KindQuery) begin
                                push_beat.running = r_hit;
                            end else if (r_cmd.kind != KindCancel && !r_hit) begin
                                push_beat.status = StatusNoSlot;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_pend_valid = 1'b0;
                    n_state = StIdle;
                end
            end
            default: begin
                n_state = StIdle;
            end
        endcase

        n_out_valid = r_out_valid;
        n_out = r_out;
        if (push) begin
            n_out_valid = 1'b1;
            n_out = push_beat;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StIdle;
            r_armed <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_hit <= 1'b0;
            r_nfire <= '0;
            r_idx <= '0;
        end else begin
            r_state <= n_state;
            r_armed <= n_armed;
            r_pend_valid <= n_pend_valid;
            r_out_valid <= n_out_valid;
            r_hit <= n_hit;
            r_nfire <= n_nfire;
            r_idx <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_pend_owner <= n_pend_owner;
        r_pend_tag <= n_pend_tag;
        r_out <= n_out;
    end

    assign o_in_stall = r_state != StIdle;
    assign o_out_valid = r_out_valid;
    assign o_out_beat = r_out;

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == StIdle |-> !r_pend_valid)
        else $error("pending fire beat left behind at end of command");

    a_fire_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nfire <= FireCntW'(MaxFire))
        else $error("fire count beyond limit");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state != StIdle)
        else $error("accepted command did not start");

    a_fire_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.fired |-> o_out_beat.fired_owner != 8'd0 &&
        r_out.status == StatusOk)
        else $error("fire beat for a slot without owner");

endmodule

### dv/timer_slot_table_checker.sv
// Checker for the timer slot table: predicts result beats from accepted commands and compares them.
module timer_slot_table_checker import tst_pkg::*; #(
    parameter int SLOTS = SlotsDefault
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_beat  i_in_beat,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_beat i_out_beat,
    output int        o_fail_count,
    output int        o_results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    t_slot     slots [SLOTS];
    t_out_beat results_due [$];
    t_out_beat want;
    int        fail_count = 0;

    function automatic void push_result(logic [1:0] status, logic running, logic fired,
                                        logic [7:0] owner, logic [15:0] tag, logic last);
        t_out_beat r;
        r.status = status;
        r.running = running;
        r.fired = fired;
        r.fired_owner = owner;
        r.fired_tag = tag;
        r.last = last;
        results_due.push_back(r);
    endfunction

    function automatic logic bool_match(t_slot s, t_in_beat cmd);
        return s.owner == cmd.owner_id && (cmd.data_tag == '0 || s.tag == cmd.data_tag);
    endfunction

    function automatic void apply_timer_command(t_in_beat cmd);
        int hit;
        int fired_n;
        int emitted;
        logic running;
        bit fire [SLOTS];
        hit = -1;
        fired_n = 0;
        emitted = 0;
        running = 1'b0;
        case (cmd.kind) inside
            KindStartShort, KindStartLong: begin
                if (cmd.owner_id == '0) begin
                    push_result(StatusZeroOwner, 1'b0, 1'b0, '0, '0, 1'b1);
                end else begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (hit < 0 && (slots[i].owner == '0 ||
                            (slots[i].owner == cmd.owner_id && slots[i].tag == cmd.data_tag))) begin
                            hit = i;
                        end
                    end
                    if (hit < 0) begin
                        push_result(StatusNoSlot, 1'b0, 1'b0, '0, '0, 1'b1);
                    end else begin
                        slots[hit].owner = cmd.owner_id;
                        slots[hit].tag = cmd.data_tag;
                        slots[hit].ticks = (cmd.kind == KindStartShort) ? cmd.count : '0;
                        slots[hit].seconds = (cmd.kind == KindStartLong) ? cmd.count : '0;
                        push_result(StatusOk, 1'b0, 1'b0, '0, '0, 1'b1);
                    end
                end
            end
            KindCancel: begin
                if (cmd.owner_id == '0) begin
                    push_result(StatusZeroOwner, 1'b0, 1'b0, '0, '0, 1'b1);
                end else begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (hit < 0 && bool_match(slots[i], cmd)) begin
                            slots[i].owner = '0;
                            slots[i].tag = '0;
                            if (cmd.data_tag != '0) begin
                                hit = i;
                            end
                        end
                    end
                    push_result(StatusOk, 1'b0, 1'b0, '0, '0, 1'b1);
                end
            end
            KindQuery: begin
                if (cmd.owner_id == '0) begin
                    push_result(StatusZeroOwner, 1'b0, 1'b0, '0, '0, 1'b1);
                end else begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (bool_match(slots[i], cmd)) begin
                            running = 1'b1;
                        end
                    end
                    push_result(StatusOk, running, 1'b0, '0, '0, 1'b1);
                end
            end
            KindProcess: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (cmd.tick_event && slots[i].ticks != '0) begin
                        slots[i].ticks = slots[i].ticks - 16'd1;
                    end
                    if (cmd.second_event && slots[i].seconds != '0) begin
                        slots[i].seconds = slots[i].seconds - 16'd1;
                    end
                end
                for (int i = 0; i < SLOTS; i++) begin
                    fire[i] = slots[i].owner != '0 && slots[i].ticks == '0 &&
                              slots[i].seconds == '0 && fired_n < MaxFire;
                    if (fire[i]) begin
                        fired_n++;
                    end
                end
                if (fired_n == 0) begin
                    push_result(StatusOk, 1'b0, 1'b0, '0, '0, 1'b1);
                end else begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (fire[i]) begin
                            emitted++;
                            push_result(StatusOk, 1'b0, 1'b1, slots[i].owner, slots[i].tag,
                                        emitted == fired_n);
                            slots[i].owner = '0;
                            slots[i].tag = '0;
                        end
                    end
                end
            end
            default: begin
                push_result(StatusOk, 1'b0, 1'b0, '0, '0, 1'b1);
            end
        endcase
    endfunction

    function automatic void check_field(string field, logic [31:0] want_v, logic [31:0] got_v);
        if (want_v !== got_v) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want_v, got_v);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                slots[i] = '0;
            end
            results_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result beat, expected none, got %h",
                             $time, i_out_beat);
                end else begin
                    want = results_due.pop_front();
                    check_field("status", 32'(want.status), 32'(i_out_beat.status));
                    check_field("running", 32'(want.running), 32'(i_out_beat.running));
                    check_field("fired", 32'(want.fired), 32'(i_out_beat.fired));
                    check_field("fired_owner", 32'(want.fired_owner),
                                32'(i_out_beat.fired_owner));
                    check_field("fired_tag", 32'(want.fired_tag), 32'(i_out_beat.fired_tag));
                    check_field("last", 32'(want.last), 32'(i_out_beat.last));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                apply_timer_command(i_in_beat);
            end
        end
        o_results_due = results_due.size();
        o_fail_count = fail_count;
    end

endmodule

### dv/timer_slot_table_tb.sv
// Testbench top of the timer slot table: clock, reset, command stimulus, receiver stalls and verdict.
module timer_slot_table_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tst_pkg::*;

    localparam int Slots = SlotsDefault;
    localparam int CycleLimit = 200000;
    localparam int DrainCycles = Slots + 8;
    localparam int RandomCommands = 72;
    localparam int QuietFirst = 30;
    localparam int QuietLast = 60;
    localparam logic [2:0] KindHighest = 3'd7;

    logic      clk;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_beat  in_beat = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_beat out_beat;
    int        fail_count;
    int        results_due;
    bit        quiet = 1'b0;
    int        cycle_count = 0;
    int        issued;

    timer_slot_table #(
        .SLOTS(Slots)
    ) u_top (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_stall(in_stall),
        .i_in_beat(in_beat),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_beat(out_beat)
    );

    timer_slot_table_checker #(
        .SLOTS(Slots)
    ) u_checker (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .i_in_stall(in_stall),
        .i_in_beat(in_beat),
        .i_out_valid(out_valid),
        .i_out_stall(out_stall),
        .i_out_beat(out_beat),
        .o_fail_count(fail_count),
        .o_results_due(results_due)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk) begin
        out_stall <= !quiet && ($urandom_range(0, 99) < 7);
    end

    function automatic t_in_beat make_command(logic [2:0] kind, logic [7:0] owner,
                                              logic [15:0] tag, logic [15:0] count,
                                              logic tick, logic second);
        t_in_beat c;
        c.kind = kind;
        c.owner_id = owner;
        c.data_tag = tag;
        c.count = count;
        c.tick_event = tick;
        c.second_event = second;
        return c;
    endfunction

    function automatic t_in_beat random_command();
        int pick;
        t_in_beat c;
        pick = $urandom_range(0, 99);
        if (pick < 22) begin
            c.kind = KindStartShort;
        end else if (pick < 40) begin
            c.kind = KindStartLong;
        end else if (pick < 52) begin
            c.kind = KindCancel;
        end else if (pick < 64) begin
            c.kind = KindQuery;
        end else if (pick < 95) begin
            c.kind = KindProcess;
        end else begin
            c.kind = 3'($urandom_range(KindProcess + 1, KindHighest));
        end
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            c.owner_id = '0;
        end else if (pick < 88) begin
            c.owner_id = 8'($urandom_range(1, 4));
        end else begin
            c.owner_id = 8'($urandom_range(0, 255));
        end
        c.data_tag = ($urandom_range(0, 99) < 75) ? 16'($urandom_range(0, 3))
                                                  : 16'($urandom_range(0, 65535));
        c.count = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, 4))
                                               : 16'($urandom_range(0, 65535));
        c.tick_event = 1'($urandom_range(0, 1));
        c.second_event = 1'($urandom_range(0, 1));
        return c;
    endfunction

    task automatic send_command(input t_in_beat cmd);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 99) < 7) begin
            gap = $urandom_range(1, 5);
        end
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat <= cmd;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    initial begin
        t_in_beat cmd;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        send_command(make_command(KindProcess, 8'd0, 16'd0, 16'd0, 1'b1, 1'b1));
        send_command(make_command(KindStartShort, 8'd0, 16'd7, 16'd5, 1'b0, 1'b0));
        send_command(make_command(KindCancel, 8'd0, 16'd7, 16'd0, 1'b0, 1'b0));
        send_command(make_command(KindQuery, 8'd0, 16'd0, 16'd0, 1'b0, 1'b0));
        send_command(make_command(KindHighest, 8'hff, 16'hffff, 16'hffff, 1'b1, 1'b1));
        send_command(make_command(KindStartShort, 8'hff, 16'hffff, 16'hffff, 1'b0, 1'b0));
        send_command(make_command(KindStartLong, 8'd1, 16'd0, 16'hffff, 1'b0, 1'b0));
        send_command(make_command(KindStartShort, 8'hff, 16'hffff, 16'd0, 1'b0, 1'b0));
        send_command(make_command(KindQuery, 8'd1, 16'd0, 16'd0, 1'b0, 1'b0));
        send_command(make_command(KindQuery, 8'hff, 16'd1, 16'd0, 1'b0, 1'b0));
        send_command(make_command(KindCancel, 8'd1, 16'd0, 16'd0, 1'b0, 1'b0));
        for (int k = 2; k <= Slots; k++) begin
            send_command(make_command(k[0] ? KindStartLong : KindStartShort, 8'(k),
                                      16'(k * 4369), 16'd0, 1'b0, 1'b0));
        end
        send_command(make_command(KindStartLong, 8'd200, 16'd9, 16'd3, 1'b0, 1'b0));
        send_command(make_command(KindProcess, 8'd0, 16'd0, 16'd0, 1'b0, 1'b0));

        issued = 0;
        while (issued < RandomCommands) begin
            quiet <= (issued >= QuietFirst && issued < QuietLast);
            cmd = random_command();
            send_command(cmd);
            issued++;
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### sim.f
rtl/tst_pkg.sv
rtl/tst_ram.sv
rtl/timer_slot_table.sv
dv/timer_slot_table_checker.sv
dv/timer_slot_table_tb.sv
